[src/tcg_pkg.sv]
// Shared types, constants and helper functions for the texture coordinate generator.
// No dependencies; tcg_xform, tcg_atan, tcg_isqrt and the top level import this package.
package tcg_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int NORM_STAGES   = 3;
  localparam int CORDIC_STEPS  = 31;
  localparam int ATAN_LAT      = 1 + NORM_STAGES + CORDIC_STEPS;
  localparam int SQRT_STEPS    = 32;
  localparam int SQRT_PAD      = ATAN_LAT - SQRT_STEPS;

  // Mapping modes
  typedef enum logic [2:0] {
    MODE_PLANE    = 3'd0,
    MODE_SPHERE   = 3'd1,
    MODE_CYLINDER = 3'd2,
    MODE_DISC     = 3'd3,
    MODE_NONE     = 3'd4
  } map_mode_t;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_MAP_MODE = 3'd0,
    REG_WORD_A   = 3'd1,
    REG_WORD_B   = 3'd2,
    REG_WORD_C   = 3'd3,
    REG_WORD_D   = 3'd4,
    REG_WORD_E   = 3'd5,
    REG_WORD_F   = 3'd6
  } cfg_reg_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic               final_vertex;
  } in_data_t;

  typedef struct packed {
    logic signed [31:0] map_u;
    logic signed [31:0] map_v;
    logic               final_result;
  } out_data_t;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
  } vec3_t;

  // Per-beat side data that rides alongside the angle pipelines
  typedef struct packed {
    logic [2:0]         mode;
    logic signed [31:0] plane_u;
    logic signed [31:0] plane_v;
    logic               last;
  } side_t;

  // CORDIC arctangent table, binary angle units (2^32 per turn)
  function automatic logic [31:0] angle_step(input int i);
    logic [31:0] t;
    case (i)
      0:  t = 32'd536870912;
      1:  t = 32'd316933406;
      2:  t = 32'd167458907;
      3:  t = 32'd85004756;
      4:  t = 32'd42667331;
      5:  t = 32'd21354465;
      6:  t = 32'd10679838;
      7:  t = 32'd5340245;
      8:  t = 32'd2670163;
      9:  t = 32'd1335087;
      10: t = 32'd667544;
      11: t = 32'd333772;
      12: t = 32'd166886;
      13: t = 32'd83443;
      14: t = 32'd41722;
      15: t = 32'd20861;
      16: t = 32'd10430;
      17: t = 32'd5215;
      18: t = 32'd2608;
      19: t = 32'd1304;
      20: t = 32'd652;
      21: t = 32'd326;
      22: t = 32'd163;
      23: t = 32'd81;
      24: t = 32'd41;
      25: t = 32'd20;
      26: t = 32'd10;
      27: t = 32'd5;
      28: t = 32'd3;
      29: t = 32'd1;
      30: t = 32'd1;
      default: t = 32'd0;
    endcase
    return t;
  endfunction

  // Clamp to the signed 32-bit range
  function automatic logic signed [31:0] sat32(input logic signed [66:0] v);
    logic signed [31:0] r;
    if (v > 67'sd2147483647) begin
      r = 32'sh7fff_ffff;
    end else if (v < -67'sd2147483648) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

[src/texture_coordinate_generator_unit.sv]
// Top level of the texture coordinate generator: config registers, operand prep, result stage.
// Depends on tcg_pkg, tcg_xform, tcg_atan, tcg_isqrt and tcg_delay.

// One vertex beat enters per clock and its (u,v) beat leaves after the affine transform, the
// squaring and operand selection registers, the CORDIC atan2 pipelines (setup, normalize,
// 31 rotation steps; the square root runs 32 stages alongside), and the output register.
// The whole pipeline advances together; it holds only while a result waits on out_ready,
// and in_ready is low only then. Configuration writes take effect at once and must be made
// while no beats are in flight. After reset the matrix is identity and the mode is plane.
module texture_coordinate_generator_unit import tcg_pkg::*; #(
  parameter int FRACTION_BITS = FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_data_t    in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_data_t   out_data,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_wdata
);

  logic [2:0]  map_mode_r;
  logic [63:0] word_r [6];
  logic [383:0] mat_words;
  logic        adv;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      map_mode_r <= MODE_PLANE;
      word_r[0]  <= 64'(1) << FRACTION_BITS;
      word_r[1]  <= '0;
      word_r[2]  <= 64'(1) << FRACTION_BITS;
      word_r[3]  <= '0;
      word_r[4]  <= 64'(1) << FRACTION_BITS;
      word_r[5]  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_MAP_MODE: map_mode_r <= cfg_wdata[2:0];
        REG_WORD_A:   word_r[0]  <= cfg_wdata;
        REG_WORD_B:   word_r[1]  <= cfg_wdata;
        REG_WORD_C:   word_r[2]  <= cfg_wdata;
        REG_WORD_D:   word_r[3]  <= cfg_wdata;
        REG_WORD_E:   word_r[4]  <= cfg_wdata;
        REG_WORD_F:   word_r[5]  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign mat_words = {word_r[5], word_r[4], word_r[3], word_r[2], word_r[1], word_r[0]};

  // pipeline moves unless a finished beat is waiting
  logic out_vld_r;
  assign adv      = !out_vld_r || out_ready;
  assign in_ready = adv;

  // affine transform
  logic  x_vld, x_last;
  vec3_t x_pos;

  tcg_xform #(.FRACTION_BITS(FRACTION_BITS)) u_xform (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_vld    (in_valid),
    .in_data   (in_data),
    .mat_words (mat_words),
    .out_vld   (x_vld),
    .out_pos   (x_pos),
    .out_last  (x_last)
  );

  // squares
  logic               q1_vld_r, q1_last_r;
  vec3_t              q1_pos_r;
  logic signed [63:0] sqx_r, sqy_r, sqz_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q1_vld_r <= 1'b0;
    end else if (adv) begin
      q1_vld_r <= x_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      q1_last_r <= x_last;
      q1_pos_r  <= x_pos;
      sqx_r     <= x_pos.x * x_pos.x;
      sqy_r     <= x_pos.y * x_pos.y;
      sqz_r     <= x_pos.z * x_pos.z;
    end
  end

  // operand selection for the angle and root pipelines
  logic [63:0]        sum_xz, n_nxt;
  logic signed [63:0] ua_nxt, ub_nxt, va_nxt, vb_nxt;
  logic signed [33:0] pu_sum, pv_sum;
  side_t              side_nxt;

  always_comb begin
    sum_xz = 64'(sqx_r) + 64'(sqz_r);
    n_nxt  = 64'(sqx_r) + 64'(sqy_r);
    ua_nxt = (map_mode_r == MODE_DISC) ? -64'(q1_pos_r.y) : -64'(q1_pos_r.z);
    ub_nxt = 64'(q1_pos_r.x);
    va_nxt = $signed(sum_xz >> FRACTION_BITS);
    vb_nxt = 64'(q1_pos_r.y);
    pu_sum = (34'(q1_pos_r.x) + (34'sd1 <<< FRACTION_BITS)) >>> 1;
    pv_sum = (34'(q1_pos_r.y) + (34'sd1 <<< FRACTION_BITS)) >>> 1;
    side_nxt.mode    = map_mode_r;
    side_nxt.plane_u = pu_sum[31:0];
    side_nxt.plane_v = pv_sum[31:0];
    side_nxt.last    = q1_last_r;
  end

  logic               q2_vld_r;
  logic [63:0]        n_r;
  logic signed [63:0] ua_r, ub_r, va_r, vb_r;
  side_t              side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q2_vld_r <= 1'b0;
    end else if (adv) begin
      q2_vld_r <= q1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      n_r    <= n_nxt;
      ua_r   <= ua_nxt;
      ub_r   <= ub_nxt;
      va_r   <= va_nxt;
      vb_r   <= vb_nxt;
      side_r <= side_nxt;
    end
  end

  // angle, root and side-data pipelines, all ATAN_LAT deep
  logic        au_vld, av_vld, sq_vld, sqd_vld, sd_vld;
  logic [31:0] ang_u, ang_v;
  logic [32:0] root, root_d;
  side_t       sd;

  tcg_atan u_atan_u (
    .clk (clk), .rst_n (rst_n), .adv (adv), .in_vld (q2_vld_r),
    .in_a (ua_r), .in_b (ub_r), .out_vld (au_vld), .out_ang (ang_u)
  );

  tcg_atan u_atan_v (
    .clk (clk), .rst_n (rst_n), .adv (adv), .in_vld (q2_vld_r),
    .in_a (va_r), .in_b (vb_r), .out_vld (av_vld), .out_ang (ang_v)
  );

  tcg_isqrt u_isqrt (
    .clk (clk), .rst_n (rst_n), .adv (adv), .in_vld (q2_vld_r),
    .in_n (n_r), .out_vld (sq_vld), .out_root (root)
  );

  tcg_delay #(.WIDTH(33), .DEPTH(SQRT_PAD)) u_root_pad (
    .clk (clk), .rst_n (rst_n), .adv (adv), .in_vld (sq_vld),
    .in_dat (root), .out_vld (sqd_vld), .out_dat (root_d)
  );

  tcg_delay #(.WIDTH($bits(side_t)), .DEPTH(ATAN_LAT)) u_side (
    .clk (clk), .rst_n (rst_n), .adv (adv), .in_vld (q2_vld_r),
    .in_dat (side_r), .out_vld (sd_vld), .out_dat (sd)
  );

  // final mapping and rounding
  logic signed [31:0] su, sv;
  logic signed [33:0] turn_u, sph_q, sph_v, u34, v34;

  always_comb begin
    su     = $signed(ang_u);
    sv     = $signed(ang_v - 32'h4000_0000);
    turn_u = (34'(su) + (34'sd1 <<< (31 - FRACTION_BITS))) >>> (32 - FRACTION_BITS);
    sph_q  = (34'(sv) + (34'sd1 <<< (30 - FRACTION_BITS))) >>> (31 - FRACTION_BITS);
    sph_v  = (34'sd1 <<< (FRACTION_BITS - 1)) - sph_q;
    case (sd.mode)
      MODE_PLANE: begin
        u34 = 34'(sd.plane_u);
        v34 = 34'(sd.plane_v);
      end
      MODE_SPHERE: begin
        u34 = turn_u;
        v34 = sph_v;
      end
      MODE_CYLINDER: begin
        u34 = turn_u;
        v34 = 34'(sd.plane_v);
      end
      MODE_DISC: begin
        u34 = turn_u;
        v34 = $signed({1'b0, root_d});
      end
      default: begin
        u34 = '0;
        v34 = '0;
      end
    endcase
  end

  // output register
  out_data_t out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= sd_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data_r.map_u        <= sat32(67'(u34));
      out_data_r.map_v        <= sat32(67'(v34));
      out_data_r.final_result <= sd.last;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_data_r;

`ifndef SYNTHESIS
  // all parallel pipelines stay in step
  a_lanes_aligned: assert property (@(posedge clk) disable iff (!rst_n)
    (au_vld == sd_vld) && (av_vld == sd_vld) && (sqd_vld == sd_vld))
    else $error("angle/root/side pipelines out of step");

  // a waiting result blocks intake
  a_stall_blocks_in: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |-> !in_ready)
    else $error("input taken while output stalled");

  // mode none gives zero coordinates
  a_none_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && map_mode_r == MODE_NONE) |-> (out_data.map_u == 0 && out_data.map_v == 0))
    else $error("mode none produced nonzero output");

  // turn fraction stays within half a turn
  a_u_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (map_mode_r == MODE_SPHERE || map_mode_r == MODE_CYLINDER))
    |-> (out_data.map_u <= (32'sd1 <<< (FRACTION_BITS - 1))
         && out_data.map_u >= -(32'sd1 <<< (FRACTION_BITS - 1))))
    else $error("u outside half-turn range");
`endif

endmodule

[src/tcg_delay.sv]
// Stall-aware delay line that carries a valid bit with its data.
// Depends on nothing but its parameters.
module tcg_delay #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 1
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             adv,
  input  logic             in_vld,
  input  logic [WIDTH-1:0] in_dat,
  output logic             out_vld,
  output logic [WIDTH-1:0] out_dat
);

  logic             vld_r [DEPTH];
  logic [WIDTH-1:0] dat_r [DEPTH];

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < DEPTH; i++) vld_r[i] <= 1'b0;
    end else if (adv) begin
      vld_r[0] <= in_vld;
      for (int i = 1; i < DEPTH; i++) vld_r[i] <= vld_r[i-1];
    end
  end

  // data taps
  always_ff @(posedge clk) begin
    if (adv) begin
      dat_r[0] <= in_dat;
      for (int i = 1; i < DEPTH; i++) dat_r[i] <= dat_r[i-1];
    end
  end

  assign out_vld = vld_r[DEPTH-1];
  assign out_dat = dat_r[DEPTH-1];

endmodule

[src/tcg_xform.sv]
// Three-stage affine transform: nine products, column sums, translate and clamp.
// Depends on tcg_pkg.
module tcg_xform import tcg_pkg::*; #(
  parameter int FRACTION_BITS = FRAC_BITS_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           adv,
  input  logic           in_vld,
  input  in_data_t       in_data,
  input  logic [383:0]   mat_words,
  output logic           out_vld,
  output vec3_t          out_pos,
  output logic           out_last
);

  logic signed [31:0] pin [3];
  logic signed [63:0] prod_r [9];
  logic signed [65:0] sum_r [3];
  logic signed [31:0] pos_r [3];
  logic               vld_r [3];
  logic               last_r [3];

  assign pin[0] = in_data.pos_x;
  assign pin[1] = in_data.pos_y;
  assign pin[2] = in_data.pos_z;

  // valid and last marker
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < 3; s++) vld_r[s] <= 1'b0;
    end else if (adv) begin
      vld_r[0] <= in_vld;
      vld_r[1] <= vld_r[0];
      vld_r[2] <= vld_r[1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      last_r[0] <= in_data.final_vertex;
      last_r[1] <= last_r[0];
      last_r[2] <= last_r[1];
    end
  end

  // stage 1: coefficient k = i*3+j multiplies component i into column j
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          prod_r[i*3+j] <= pin[i] * $signed(mat_words[32*(i*3+j) +: 32]);
        end
      end
    end
  end

  // stage 2: exact column sums
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int j = 0; j < 3; j++) begin
        sum_r[j] <= 66'(prod_r[j]) + 66'(prod_r[3+j]) + 66'(prod_r[6+j]);
      end
    end
  end

  // stage 3: floor to fixed point, add translation, clamp
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int j = 0; j < 3; j++) begin
        pos_r[j] <= sat32(67'((sum_r[j] >>> FRACTION_BITS)
                              + 66'($signed(mat_words[32*(9+j) +: 32]))));
      end
    end
  end

  assign out_vld   = vld_r[2];
  assign out_last  = last_r[2];
  assign out_pos.x = pos_r[0];
  assign out_pos.y = pos_r[1];
  assign out_pos.z = pos_r[2];

endmodule

[src/tcg_atan.sv]
// Pipelined CORDIC atan2 in binary angle units: setup, 3 normalize stages, 31 steps.
// Depends on tcg_pkg (step table and stage counts).
module tcg_atan import tcg_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               adv,
  input  logic               in_vld,
  input  logic signed [63:0] in_a,
  input  logic signed [63:0] in_b,
  output logic               out_vld,
  output logic [31:0]        out_ang
);

  logic signed [63:0] a_r    [ATAN_LAT];
  logic signed [63:0] b_r    [ATAN_LAT];
  logic [63:0]        m_r    [NORM_STAGES+1];
  logic [31:0]        ang_r  [ATAN_LAT];
  logic               hold_r [ATAN_LAT];
  logic               vld_r  [ATAN_LAT];

  logic               neg;
  logic signed [63:0] a0, b0, abs_a;

  // setup: half-turn for a negative second operand, zero first operand is held
  always_comb begin
    neg   = in_b < 0;
    a0    = neg ? -in_a : in_a;
    b0    = neg ? -in_b : in_b;
    abs_a = (a0 < 0) ? -a0 : a0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < ATAN_LAT; s++) vld_r[s] <= 1'b0;
    end else if (adv) begin
      vld_r[0] <= in_vld;
      for (int s = 1; s < ATAN_LAT; s++) vld_r[s] <= vld_r[s-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_r[0]    <= a0;
      b_r[0]    <= b0;
      m_r[0]    <= (b0 > abs_a) ? 64'(b0) : 64'(abs_a);
      ang_r[0]  <= neg ? 32'h8000_0000 : 32'h0;
      hold_r[0] <= in_a == 0;
    end
  end

  // normalize: two conditional left shifts per stage until max is in [2^54, 2^55)
  for (genvar s = 0; s < NORM_STAGES; s++) begin : g_norm
    localparam int K1 = 32 >> (2 * s);
    localparam int K2 = K1 >> 1;
    logic               sh1, sh2;
    logic signed [63:0] a1, b1, a2, b2;
    logic [63:0]        m1, m2;

    always_comb begin
      sh1 = (m_r[s] >> (55 - K1)) == '0;
      a1  = sh1 ? (a_r[s] <<< K1) : a_r[s];
      b1  = sh1 ? (b_r[s] <<< K1) : b_r[s];
      m1  = sh1 ? (m_r[s] << K1) : m_r[s];
      sh2 = (m1 >> (55 - K2)) == '0;
      a2  = sh2 ? (a1 <<< K2) : a1;
      b2  = sh2 ? (b1 <<< K2) : b1;
      m2  = sh2 ? (m1 << K2) : m1;
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        a_r[s+1]    <= a2;
        b_r[s+1]    <= b2;
        m_r[s+1]    <= m2;
        ang_r[s+1]  <= ang_r[s];
        hold_r[s+1] <= hold_r[s];
      end
    end
  end

  // rotation steps, floor shifts, direction from the sign of the first operand
  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
    localparam int SRC = NORM_STAGES + i;
    logic signed [63:0] da, db, an, bn;
    logic [31:0]        angn;

    always_comb begin
      da   = a_r[SRC] >>> i;
      db   = b_r[SRC] >>> i;
      an   = a_r[SRC];
      bn   = b_r[SRC];
      angn = ang_r[SRC];
      if (!hold_r[SRC]) begin
        if (a_r[SRC] > 0) begin
          bn   = b_r[SRC] + da;
          an   = a_r[SRC] - db;
          angn = ang_r[SRC] + angle_step(i);
        end else begin
          bn   = b_r[SRC] - da;
          an   = a_r[SRC] + db;
          angn = ang_r[SRC] - angle_step(i);
        end
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        a_r[SRC+1]    <= an;
        b_r[SRC+1]    <= bn;
        ang_r[SRC+1]  <= angn;
        hold_r[SRC+1] <= hold_r[SRC];
      end
    end
  end

  assign out_vld = vld_r[ATAN_LAT-1];
  assign out_ang = ang_r[ATAN_LAT-1];

endmodule

[src/tcg_isqrt.sv]
// Pipelined 64-bit integer square root, one result bit per stage (32 stages).
// Depends on tcg_pkg (stage count).
module tcg_isqrt import tcg_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        adv,
  input  logic        in_vld,
  input  logic [63:0] in_n,
  output logic        out_vld,
  output logic [32:0] out_root
);

  logic [63:0] n_r   [SQRT_STEPS+1];
  logic [63:0] res_r [SQRT_STEPS+1];
  logic        vld_r [SQRT_STEPS+1];

  assign n_r[0]   = in_n;
  assign res_r[0] = '0;
  assign vld_r[0] = in_vld;

  for (genvar i = 0; i < SQRT_STEPS; i++) begin : g_step
    localparam logic [63:0] BIT = 64'(1) << (62 - 2 * i);
    logic [63:0] trial, nn, rn;

    always_comb begin
      trial = res_r[i] + BIT;
      if (n_r[i] >= trial) begin
        nn = n_r[i] - trial;
        rn = (res_r[i] >> 1) + BIT;
      end else begin
        nn = n_r[i];
        rn = res_r[i] >> 1;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i+1] <= 1'b0;
      end else if (adv) begin
        vld_r[i+1] <= vld_r[i];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        n_r[i+1]   <= nn;
        res_r[i+1] <= rn;
      end
    end
  end

  assign out_vld  = vld_r[SQRT_STEPS];
  assign out_root = res_r[SQRT_STEPS][32:0];

endmodule

[bench/texture_coordinate_generator_unit_test.sv]
// Self-checking bench for texture_coordinate_generator_unit: directed table, then random phases.
// Depends on tcg_pkg and the RTL under src/. Beats are checked against a built-in mapper or typed values.
module texture_coordinate_generator_unit_test;
  import tcg_pkg::*;

  localparam int FB = 16;
  localparam logic [2:0] MODE_SPARE = 3'd5;
  localparam logic [2:0] REG_UNUSED = 3'd7;
  localparam int PHASES = 15;
  localparam int PHASE_BEATS = 60;
  localparam int CYCLE_LIMIT = 1000000;
  localparam logic signed [31:0] PMAX = 32'sh7fff_ffff;
  localparam logic signed [31:0] PMIN = 32'sh8000_0000;

  localparam bit [31:0] ROT_ANGLE [31] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886,
    83443, 41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163,
    81, 41, 20, 10, 5, 3, 1, 1};

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  in_data_t    in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_data_t   out_data;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [63:0] cfg_wdata = '0;

  // mirrored configuration
  logic [2:0]  cur_mode;
  bit   [63:0] mat_words [6];

  out_data_t pending_maps [$];
  int errors = 0;
  int beats_sent = 0;
  int beats_seen = 0;
  int cycles = 0;
  bit quiet = 1'b0;

  texture_coordinate_generator_unit dut (.*);

  always #1 clk = ~clk;

  // ---------------- mapper ----------------
  function automatic longint sx32(bit [31:0] w);
    return longint'($signed(w));
  endfunction

  function automatic longint clamp32(longint v);
    if (v > longint'(PMAX)) return longint'(PMAX);
    if (v < longint'(PMIN)) return longint'(PMIN);
    return v;
  endfunction

  function automatic longint coef(int k);
    bit [63:0] w;
    w = mat_words[k >> 1];
    return (k & 1) ? sx32(w[63:32]) : sx32(w[31:0]);
  endfunction

  // atan2(a, b) in binary angle units, 2^32 per turn
  function automatic bit [31:0] cordic_angle(longint a, longint b);
    bit [31:0] ang;
    longint m, da, db;
    ang = '0;
    if (a == 0) return (b < 0) ? 32'h8000_0000 : 32'h0;
    if (b < 0) begin
      a = -a;
      b = -b;
      ang = 32'h8000_0000;
    end
    m = (a < 0) ? -a : a;
    if (b > m) m = b;
    while (m < (64'sd1 <<< 54)) begin
      a = a * 2;
      b = b * 2;
      m = m * 2;
    end
    for (int i = 0; i < 31; i++) begin
      da = a >>> i;
      db = b >>> i;
      if (a > 0) begin
        b = b + da;
        a = a - db;
        ang = ang + ROT_ANGLE[i];
      end else begin
        b = b - da;
        a = a + db;
        ang = ang - ROT_ANGLE[i];
      end
    end
    return ang;
  endfunction

  function automatic longint turn_part(longint a, longint b);
    longint s;
    s = sx32(cordic_angle(a, b));
    return (s + (64'sd1 <<< (31 - FB))) >>> (32 - FB);
  endfunction

  function automatic longint unsigned sum_sq(longint a, longint b);
    return longint'(a * a) + longint'(b * b);
  endfunction

  function automatic longint unsigned root64(longint unsigned n);
    longint unsigned res, bt;
    res = 0;
    bt = 64'd1 << 62;
    while (bt > n) bt = bt >> 2;
    while (bt != 0) begin
      if (n >= res + bt) begin
        n = n - (res + bt);
        res = (res >> 1) + bt;
      end else begin
        res = res >> 1;
      end
      bt = bt >> 2;
    end
    return res;
  endfunction

  function automatic out_data_t map_vertex(in_data_t d);
    out_data_t r;
    longint p [3], mv [3];
    longint hi, lo, prod, h, u, v, dd, s;
    p[0] = d.pos_x;
    p[1] = d.pos_y;
    p[2] = d.pos_z;
    // affine transform, floored sum of exact products
    for (int j = 0; j < 3; j++) begin
      hi = coef(9 + j);
      lo = 0;
      for (int i = 0; i < 3; i++) begin
        prod = p[i] * coef(i * 3 + j);
        h = prod >>> FB;
        hi = hi + h;
        lo = lo + (prod - (h <<< FB));
      end
      mv[j] = clamp32(hi + (lo >>> FB));
    end
    u = 0;
    v = 0;
    case (cur_mode)
      MODE_PLANE: begin
        u = (mv[0] + (64'sd1 <<< FB)) >>> 1;
        v = (mv[1] + (64'sd1 <<< FB)) >>> 1;
      end
      MODE_SPHERE: begin
        dd = longint'(sum_sq(mv[0], mv[2]) >> FB);
        s = sx32(cordic_angle(dd, mv[1]) - 32'h4000_0000);
        u = turn_part(-mv[2], mv[0]);
        v = (64'sd1 <<< (FB - 1)) - ((s + (64'sd1 <<< (30 - FB))) >>> (31 - FB));
      end
      MODE_CYLINDER: begin
        u = turn_part(-mv[2], mv[0]);
        v = (mv[1] + (64'sd1 <<< FB)) >>> 1;
      end
      MODE_DISC: begin
        u = turn_part(-mv[1], mv[0]);
        v = longint'(root64(sum_sq(mv[0], mv[1])));
      end
      default: ;
    endcase
    r.map_u = clamp32(u);
    r.map_v = clamp32(v);
    r.final_result = d.final_vertex;
    return r;
  endfunction

  // ---------------- idling ----------------
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // ---------------- drivers ----------------
  task automatic write_reg(logic [2:0] idx, bit [63:0] val);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_wdata = val;
    @(negedge clk);
    cfg_we = 1'b0;
    if (idx == REG_MAP_MODE) cur_mode = val[2:0];
    else if (idx <= REG_WORD_F) mat_words[idx - 1] = val;
  endtask

  // push one vertex beat; typed expectation overrides the mapper when given
  // valid stays up after the accepting edge; the next falling edge drops or reloads it
  task automatic send_vertex(in_data_t d, bit typed, out_data_t want);
    int g;
    g = gap_len();
    @(negedge clk);
    if (g > 0) begin
      in_valid = 1'b0;
      repeat (g) @(negedge clk);
    end
    in_valid = 1'b1;
    in_data = d;
    do @(posedge clk); while (!in_ready);
    pending_maps.push_back(typed ? want : map_vertex(d));
    beats_sent++;
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_maps.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // receiver stalls
  int stall_left = 0;
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      out_ready = 1'b0;
    end else begin
      stall_left = gap_len();
      out_ready = (stall_left == 0);
    end
  end

  // result checker
  always @(posedge clk) begin
    out_data_t exp_beat;
    cycles++;
    if (rst_n && out_valid && out_ready) begin
      beats_seen++;
      if (pending_maps.size() == 0) begin
        $display("%0t: unexpected beat u=%0d v=%0d", $time, out_data.map_u, out_data.map_v);
        errors++;
      end else begin
        exp_beat = pending_maps.pop_front();
        if (out_data.map_u !== exp_beat.map_u) begin
          $display("%0t: map_u expected %0d got %0d", $time, exp_beat.map_u, out_data.map_u);
          errors++;
        end
        if (out_data.map_v !== exp_beat.map_v) begin
          $display("%0t: map_v expected %0d got %0d", $time, exp_beat.map_v, out_data.map_v);
          errors++;
        end
        if (out_data.final_result !== exp_beat.final_result) begin
          $display("%0t: final_result expected %0b got %0b", $time,
                   exp_beat.final_result, out_data.final_result);
          errors++;
        end
      end
    end
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("texture_coordinate_generator_unit test failed");
      $finish;
    end
  end

  // ---------------- directed table ----------------
  typedef struct packed {
    logic [2:0]  mode;
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    logic        last;
    logic        typed;
    logic [31:0] eu;
    logic [31:0] ev;
  } dir_row_t;

  localparam int DIR_ROWS = 17;
  dir_row_t dir_rows [DIR_ROWS];

  initial begin
    dir_rows = '{
      // identity matrix throughout; origin and extremes first
      '{MODE_PLANE, 0, 0, 0, 0, 1, 32768, 32768},
      '{MODE_PLANE, PMAX, PMIN, 0, 0, 1, 1073774591, -1073709056},
      '{MODE_PLANE, PMIN, PMAX, PMAX, 0, 0, 0, 0},
      '{MODE_PLANE, 32'h1234_5678, 32'hedcb_a987, 32'h5555_aaaa, 0, 0, 0, 0},
      // origin: both angles start from zero operands
      '{MODE_SPHERE, 0, 0, 0, 0, 1, 0, 65536},
      // on the pole below: zero radius with negative y gives v of zero
      '{MODE_SPHERE, 0, -65536, 0, 0, 1, 0, 0},
      // zero z with negative x: u is minus one half
      '{MODE_SPHERE, -65536, 0, 0, 0, 0, 0, 0},
      '{MODE_SPHERE, 65536, 32768, -65536, 0, 0, 0, 0},
      '{MODE_SPHERE, PMAX, PMAX, PMIN, 1, 0, 0, 0},
      '{MODE_CYLINDER, 0, 0, 65536, 0, 0, 0, 0},
      '{MODE_CYLINDER, PMIN, PMIN, PMIN, 0, 0, 0, 0},
      '{MODE_DISC, 196608, 262144, 0, 0, 0, 0, 0},
      '{MODE_DISC, PMIN, PMIN, 0, 0, 0, 0, 0},
      '{MODE_DISC, -65536, 0, 0, 0, 0, 0, 0},
      '{MODE_NONE, PMAX, PMAX, PMAX, 1, 1, 0, 0},
      // spare mode code behaves as none
      '{MODE_SPARE, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 0, 1, 0, 0},
      '{MODE_SPARE, 0, 0, 0, 1, 1, 0, 0}};
  end

  // ---------------- random content ----------------
  function automatic logic [31:0] rand_pos();
    int k;
    k = $urandom_range(0, 9);
    if (k < 5) return 32'($signed($urandom_range(0, 524287)) - 262144);
    if (k < 8) return $urandom;
    if (k == 8) return 0;
    return ($urandom_range(0, 1) != 0) ? PMAX : PMIN;
  endfunction

  function automatic logic [31:0] rand_coef(int kind);
    case (kind)
      1: return 32'($signed($urandom_range(0, 262143)) - 131072);
      2: begin
        case ($urandom_range(0, 2))
          0: return PMAX;
          1: return PMIN;
          default: return 0;
        endcase
      end
      default: return $urandom;
    endcase
  endfunction

  // ---------------- main sequence ----------------
  initial begin
    in_data_t d;
    out_data_t want;
    bit [63:0] w;
    int kind;
    cur_mode = MODE_PLANE;
    mat_words = '{64'd65536, 64'd0, 64'd65536, 64'd0, 64'd65536, 64'd0};
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed part, in reset configuration apart from the mode
    foreach (dir_rows[i]) begin
      if (dir_rows[i].mode != cur_mode) begin
        drain();
        write_reg(REG_MAP_MODE, {$urandom, $urandom} & ~64'd7 | 64'(dir_rows[i].mode));
      end
      d.pos_x = dir_rows[i].x;
      d.pos_y = dir_rows[i].y;
      d.pos_z = dir_rows[i].z;
      d.final_vertex = dir_rows[i].last;
      want.map_u = dir_rows[i].eu;
      want.map_v = dir_rows[i].ev;
      want.final_result = dir_rows[i].last;
      send_vertex(d, dir_rows[i].typed, want);
    end

    // random phases; each rewrites every register while idle
    for (int ph = 0; ph < PHASES; ph++) begin
      drain();
      quiet = (ph % 4 == 3);
      kind = (ph == 0) ? 0 : (ph == PHASES - 1) ? 3 : $urandom_range(0, 3);
      for (int k = 0; k < 6; k++) begin
        if (kind == 0) begin
          w = (k % 2 == 0) ? 64'd65536 : 64'd0;
        end else if (kind == 3) begin
          w = {$urandom, $urandom};
        end else begin
          w = {rand_coef(kind), rand_coef(kind)};
          if (k >= 4 && kind == 1) w[63:32] = rand_coef(1);
        end
        write_reg(REG_WORD_A + 3'(k), w);
      end
      write_reg(REG_UNUSED, {$urandom, $urandom});
      write_reg(REG_MAP_MODE, {$urandom, $urandom} & ~64'd7 | 64'(ph % 8));
      for (int n = 0; n < PHASE_BEATS; n++) begin
        if (ph == 2 && n == PHASE_BEATS / 2) drain();
        d.pos_x = rand_pos();
        d.pos_y = rand_pos();
        d.pos_z = rand_pos();
        d.final_vertex = (n == PHASE_BEATS - 1) || ($urandom_range(0, 15) == 0);
        send_vertex(d, 1'b0, want);
      end
    end

    drain();
    repeat (50) @(negedge clk);
    $display("ran %0d vertex beats, %0d results checked, all map modes and matrix kinds",
             beats_sent, beats_seen);
    if (errors == 0 && pending_maps.size() == 0) begin
      $display("texture_coordinate_generator_unit test passed");
    end else begin
      $display("texture_coordinate_generator_unit test failed");
    end
    $finish;
  end

endmodule
